// ===== rtl/lsrae_pkg.sv =====
package lsrae_pkg;

    localparam int SAMPLE_W = 12;
    localparam int EXPO_W   = 16;
    localparam int STEP_W   = 8;
    localparam int IDX_W    = 9;
    localparam int CNT_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] LEAD_PULSES = 16'd3;
    localparam logic [CNT_W-1:0] HOLD_A_PULSES = 16'd48;
    localparam logic [CNT_W-1:0] HOLD_B_PULSES = 16'd40;

    localparam logic [SAMPLE_W-1:0] HIGH_THR_RESET = 12'd2500;
    localparam logic [SAMPLE_W-1:0] LOW_THR_RESET  = 12'd1500;
    localparam logic [STEP_W-1:0]   FALL_STEP_RESET = 8'd10;

    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_STEP = 2'd2;

    typedef enum logic [2:0] {
        PH_PRE    = 3'd0,
        PH_LEAD   = 3'd1,
        PH_EXPO   = 3'd2,
        PH_HOLD_A = 3'd3,
        PH_HOLD_B = 3'd4,
        PH_READ   = 3'd5
    } phase_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] high_thr;
        logic [SAMPLE_W-1:0] low_thr;
        logic [STEP_W-1:0]   fall_step;
    } adj_cfg_t;

endpackage

// ===== rtl/lsrae_exposure_adj.sv =====
module lsrae_exposure_adj (
    input  lsrae_pkg::adj_cfg_t                 cfg,
    input  logic [lsrae_pkg::SAMPLE_W-1:0]      peak,
    input  logic [lsrae_pkg::EXPO_W-1:0]        expo_in,
    output logic [lsrae_pkg::EXPO_W-1:0]        expo_out
);
    import lsrae_pkg::*;

    logic [SAMPLE_W-1:0] excess;
    logic [SAMPLE_W-1:0] deficit;
    logic [SAMPLE_W:0]   fall_amt;
    logic [SAMPLE_W:0]   rise_amt;
    logic [EXPO_W:0]     rise_sum;

    assign excess  = peak - cfg.high_thr;
    assign deficit = cfg.low_thr - peak;
    // ceil(1.5*e) and floor(1.5*d)
    assign fall_amt = {1'b0, excess} + ((({1'b0, excess}) + 13'd1) >> 1);
    assign rise_amt = {1'b0, deficit} + {2'b00, deficit[SAMPLE_W-1:1]};
    assign rise_sum = {1'b0, expo_in} + {{(EXPO_W-SAMPLE_W){1'b0}}, rise_amt};

    always_comb begin
        expo_out = expo_in;
        if (peak > cfg.high_thr) begin
            if ({{(EXPO_W-SAMPLE_W-1){1'b0}}, fall_amt} <= expo_in) begin
                expo_out = expo_in - {{(EXPO_W-SAMPLE_W-1){1'b0}}, fall_amt};
            end else if (expo_in > {{(EXPO_W-STEP_W){1'b0}}, cfg.fall_step}) begin
                expo_out = expo_in - {{(EXPO_W-STEP_W){1'b0}}, cfg.fall_step};
            end else begin
                expo_out = '0;
            end
        end else if (peak < cfg.low_thr) begin
            expo_out = rise_sum[EXPO_W] ? {EXPO_W{1'b1}} : rise_sum[EXPO_W-1:0];
        end
    end

endmodule

// ===== rtl/linear_sensor_readout_auto_exposure.sv =====
// Linear sensor readout with auto exposure. Each accepted request is one sensor clock
// pulse and gives exactly one result. The frame sequencer, running peak and exposure
// update all sit in one register stage, and the result lands in an output register,
// so a request is accepted on every cycle while the result side keeps up (throughput
// one request per cycle). A frame takes 1 + 3 + E + 48 + 40 + PIXELS requests, where
// E is the exposure count in force when the start line goes high; the new exposure
// count is reported with frame_end on the last pixel. Config writes are always ready
// and take effect at the next exposure update.
module linear_sensor_readout_auto_exposure #(
    parameter int PIXELS = 288
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [lsrae_pkg::SAMPLE_W-1:0]       s_video_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_start_level,
    output logic                                 m_pixel_valid,
    output logic [lsrae_pkg::IDX_W-1:0]          m_pixel_index,
    output logic [lsrae_pkg::SAMPLE_W-1:0]       m_pixel_value,
    output logic                                 m_frame_end,
    output logic [lsrae_pkg::EXPO_W-1:0]         m_exposure_cycles,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lsrae_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lsrae_pkg::SAMPLE_W-1:0]       cfg_data
);
    import lsrae_pkg::*;

    localparam logic [CNT_W-1:0] PIX_COUNT = CNT_W'(PIXELS);

    adj_cfg_t            cfg_reg;
    phase_t              phase_reg, phase_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [EXPO_W-1:0]   expo_reg, expo_next;
    logic [SAMPLE_W-1:0] peak_reg, peak_next;

    logic                out_valid_reg;
    logic                start_reg, start_next;
    logic                pvalid_reg, pvalid_next;
    logic [IDX_W-1:0]    pidx_reg, pidx_next;
    logic [SAMPLE_W-1:0] pval_reg, pval_next;
    logic                fend_reg, fend_next;

    logic                s_accept;
    logic [CNT_W-1:0]    count_inc;
    logic [SAMPLE_W-1:0] peak_cur;
    logic [EXPO_W-1:0]   expo_adj;

    assign s_ready   = !out_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign count_inc = count_reg + 16'd1;
    assign peak_cur  = (s_video_sample > peak_reg) ? s_video_sample : peak_reg;

    lsrae_exposure_adj u_adj (
        .cfg      (cfg_reg),
        .peak     (peak_cur),
        .expo_in  (expo_reg),
        .expo_out (expo_adj)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.high_thr  <= HIGH_THR_RESET;
            cfg_reg.low_thr   <= LOW_THR_RESET;
            cfg_reg.fall_step <= FALL_STEP_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_HIGH_THR:  cfg_reg.high_thr  <= cfg_data;
                REG_LOW_THR:   cfg_reg.low_thr   <= cfg_data;
                REG_FALL_STEP: cfg_reg.fall_step <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_inc;
        expo_next   = expo_reg;
        peak_next   = peak_reg;
        start_next  = 1'b0;
        pvalid_next = 1'b0;
        pidx_next   = '0;
        pval_next   = '0;
        fend_next   = 1'b0;
        case (phase_reg)
            PH_LEAD: begin
                start_next = 1'b1;
                if (count_inc >= LEAD_PULSES) begin
                    count_next = '0;
                    phase_next = (expo_reg != '0) ? PH_EXPO : PH_HOLD_A;
                end
            end
            PH_EXPO: begin
                start_next = 1'b1;
                if (count_inc >= expo_reg) begin
                    count_next = '0;
                    phase_next = PH_HOLD_A;
                end
            end
            PH_HOLD_A: begin
                if (count_inc >= HOLD_A_PULSES) begin
                    count_next = '0;
                    phase_next = PH_HOLD_B;
                end
            end
            PH_HOLD_B: begin
                if (count_inc >= HOLD_B_PULSES) begin
                    count_next = '0;
                    phase_next = PH_READ;
                    peak_next  = '0;
                end
            end
            PH_READ: begin
                pvalid_next = 1'b1;
                pidx_next   = count_reg[IDX_W-1:0];
                pval_next   = s_video_sample;
                peak_next   = peak_cur;
                if (count_inc >= PIX_COUNT) begin
                    fend_next  = 1'b1;
                    expo_next  = expo_adj;
                    count_next = '0;
                    phase_next = PH_PRE;
                end
            end
            default: begin
                // pre-start pulse, also covers unused codes
                count_next = '0;
                phase_next = PH_LEAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_PRE;
            count_reg     <= '0;
            expo_reg      <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                expo_reg  <= expo_next;
                peak_reg  <= peak_next;
            end
            if (s_accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            start_reg  <= start_next;
            pvalid_reg <= pvalid_next;
            pidx_reg   <= pidx_next;
            pval_reg   <= pval_next;
            fend_reg   <= fend_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_start_level     = start_reg;
    assign m_pixel_valid     = pvalid_reg;
    assign m_pixel_index     = pidx_reg;
    assign m_pixel_value     = pval_reg;
    assign m_frame_end       = fend_reg;
    assign m_exposure_cycles = expo_reg;

    // a readout request always yields a pixel
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && phase_reg == PH_READ |=> m_valid && m_pixel_valid)
        else $error("readout request did not produce a pixel");

    // the start line is never high while a pixel is read
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_pixel_valid && m_start_level))
        else $error("pixel reported with start high");

    // end of frame sends the sequencer back to the pre-start pulse
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && fend_next |=> phase_reg == PH_PRE && count_reg == '0)
        else $error("frame end did not restart the frame");

    // exposure count only changes at frame end
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_accept && fend_next) |=> $stable(expo_reg))
        else $error("exposure changed outside frame end");

endmodule

// ===== test/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsrae_pkg::*;

    localparam int PIXELS = 288;
    localparam int RESET_CYCLES = 12;
    localparam int MAX_WAIT = 16;
    localparam int QUIET_LIMIT = 1000;
    localparam int RANDOM_PIXELS = 550;
    localparam int BOOT_ROWS = 25;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [EXPO_W-1:0] EXPO_MAX = '1;

    typedef struct packed {
        logic                start_level;
        logic                pixel_valid;
        logic [IDX_W-1:0]    pixel_index;
        logic [SAMPLE_W-1:0] pixel_value;
        logic                frame_end;
        logic [EXPO_W-1:0]   exposure_cycles;
    } pulse_out_t;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        pulse_out_t          want;
    } boot_row_t;

    localparam pulse_out_t START_LOW  = '{start_level: 1'b0, default: '0};
    localparam pulse_out_t START_HIGH = '{start_level: 1'b1, default: '0};

    // first pulses after reset: exposure is zero, so start is high for the lead pulses only
    boot_row_t boot_rows [BOOT_ROWS] = '{
        '{12'h000, START_LOW},
        '{12'hFFF, START_HIGH}, '{12'hAAA, START_HIGH}, '{12'h555, START_HIGH},
        '{12'h001, START_LOW}, '{12'h800, START_LOW}, '{12'hFFE, START_LOW},
        '{12'h7FF, START_LOW}, '{12'h123, START_LOW}, '{12'hEDC, START_LOW},
        '{12'h0F0, START_LOW}, '{12'hF0F, START_LOW}, '{12'h3C3, START_LOW},
        '{12'hC3C, START_LOW}, '{12'h000, START_LOW}, '{12'hFFF, START_LOW},
        '{12'h246, START_LOW}, '{12'h9BD, START_LOW}, '{12'h400, START_LOW},
        '{12'h200, START_LOW}, '{12'h100, START_LOW}, '{12'h080, START_LOW},
        '{12'h040, START_LOW}, '{12'h020, START_LOW}, '{12'h010, START_LOW}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [SAMPLE_W-1:0]  s_video_sample = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_start_level;
    logic                 m_pixel_valid;
    logic [IDX_W-1:0]     m_pixel_index;
    logic [SAMPLE_W-1:0]  m_pixel_value;
    logic                 m_frame_end;
    logic [EXPO_W-1:0]    m_exposure_cycles;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SAMPLE_W-1:0]  cfg_data = '0;

    // sequencer mirror
    phase_t            seq_phase;
    logic [CNT_W-1:0]  seq_count;
    logic [EXPO_W-1:0] expo_count;
    logic [SAMPLE_W-1:0] peak;
    adj_cfg_t          adj;

    pulse_out_t pending [$];
    int         fails;
    bit         gaps_on;
    bit         frame_done;
    int         pixels_sent;
    int         quiet_cycles = 0;
    int         stall = 1;

    always #2 aclk = ~aclk;

    linear_sensor_readout_auto_exposure #(.PIXELS(PIXELS)) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_video_sample    (s_video_sample),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_start_level     (m_start_level),
        .m_pixel_valid     (m_pixel_valid),
        .m_pixel_index     (m_pixel_index),
        .m_pixel_value     (m_pixel_value),
        .m_frame_end       (m_frame_end),
        .m_exposure_cycles (m_exposure_cycles),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    function automatic void update_exposure();
        int unsigned over;
        int unsigned cut;
        int unsigned under;
        int unsigned sum;
        if (peak > adj.high_thr) begin
            over = peak - adj.high_thr;
            cut = over + ((over + 1) >> 1);
            if (cut <= expo_count) begin
                expo_count = EXPO_W'(expo_count - cut);
            end else if (expo_count > adj.fall_step) begin
                expo_count = expo_count - adj.fall_step;
            end else begin
                expo_count = '0;
            end
        end else if (peak < adj.low_thr) begin
            under = adj.low_thr - peak;
            sum = expo_count + under + (under >> 1);
            expo_count = (sum > EXPO_MAX) ? EXPO_MAX : sum[EXPO_W-1:0];
        end
    endfunction

    function automatic pulse_out_t step_sequencer(logic [SAMPLE_W-1:0] sample);
        pulse_out_t r;
        r = '0;
        case (seq_phase)
            PH_LEAD: begin
                r.start_level = 1'b1;
                seq_count++;
                if (seq_count >= LEAD_PULSES) begin
                    seq_count = '0;
                    if (expo_count != 0) seq_phase = PH_EXPO;
                    else seq_phase = PH_HOLD_A;
                end
            end
            PH_EXPO: begin
                r.start_level = 1'b1;
                seq_count++;
                if (seq_count >= expo_count) begin
                    seq_count = '0;
                    seq_phase = PH_HOLD_A;
                end
            end
            PH_HOLD_A: begin
                seq_count++;
                if (seq_count >= HOLD_A_PULSES) begin
                    seq_count = '0;
                    seq_phase = PH_HOLD_B;
                end
            end
            PH_HOLD_B: begin
                seq_count++;
                if (seq_count >= HOLD_B_PULSES) begin
                    seq_count = '0;
                    seq_phase = PH_READ;
                    peak = '0;
                end
            end
            PH_READ: begin
                r.pixel_valid = 1'b1;
                r.pixel_index = seq_count[IDX_W-1:0];
                r.pixel_value = sample;
                if (sample > peak) peak = sample;
                seq_count++;
                if (seq_count >= PIXELS) begin
                    r.frame_end = 1'b1;
                    update_exposure();
                    seq_count = '0;
                    seq_phase = PH_PRE;
                end
            end
            default: begin
                seq_count = '0;
                seq_phase = PH_LEAD;
            end
        endcase
        r.exposure_cycles = expo_count;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_peak();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: if (adj.high_thr >= adj.low_thr)
                return SAMPLE_W'($urandom_range(adj.low_thr, adj.high_thr));
            3: if (adj.high_thr != '1)
                return SAMPLE_W'(adj.high_thr + $urandom_range(1, 3));
            4: if (adj.low_thr != '0) return adj.low_thr - 1'b1;
            default: ;
        endcase
        return SAMPLE_W'($urandom_range(0, 4095));
    endfunction

    task automatic send_pulse(input logic [SAMPLE_W-1:0] sample, input bit typed,
                              input pulse_out_t want);
        int gap;
        pulse_out_t predicted;
        gap = gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_video_sample <= sample;
        do @(posedge aclk); while (!s_ready);
        predicted = step_sequencer(sample);
        frame_done = predicted.frame_end;
        pending.push_back(typed ? want : predicted);
    endtask

    // hold the sender off until every result has come back
    task automatic drain();
        s_valid <= 1'b0;
        while (pending.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_HIGH_THR:  adj.high_thr = data;
            REG_LOW_THR:   adj.low_thr = data;
            REG_FALL_STEP: adj.fall_step = data[STEP_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // low threshold kept small so exposure phases stay short
    task automatic write_random_reg(input logic [CFG_IDX_W-1:0] idx);
        if (idx == REG_LOW_THR) write_reg(idx, SAMPLE_W'($urandom_range(0, 300)));
        else write_reg(idx, SAMPLE_W'($urandom_range(0, 4095)));
    endtask

    task automatic run_frame(input logic [SAMPLE_W-1:0] peak_target, input int cfg_at,
                             input bit allow_gaps);
        int spot;
        logic [SAMPLE_W-1:0] sample;
        spot = $urandom_range(0, PIXELS - 1);
        gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
        do begin
            if (seq_phase == PH_READ) begin
                if (seq_count == cfg_at) begin
                    drain();
                    write_random_reg(CFG_IDX_W'($urandom_range(0, 3)));
                end
                if (seq_count == spot) sample = peak_target;
                else sample = SAMPLE_W'($urandom_range(0, peak_target));
                pixels_sent++;
            end else begin
                sample = SAMPLE_W'($urandom);
            end
            send_pulse(sample, 1'b0, '0);
        end while (!frame_done);
    endtask

    always @(posedge aclk) begin
        int draw;
        pulse_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall <= 1;
        end else begin
            if (m_valid && m_ready) begin
                if (pending.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    fails++;
                end else begin
                    want = pending.pop_front();
                    check_field("start_level", want.start_level, m_start_level);
                    check_field("pixel_valid", want.pixel_valid, m_pixel_valid);
                    check_field("pixel_index", want.pixel_index, m_pixel_index);
                    check_field("pixel_value", want.pixel_value, m_pixel_value);
                    check_field("frame_end", want.frame_end, m_frame_end);
                    check_field("exposure_cycles", want.exposure_cycles, m_exposure_cycles);
                end
                draw = gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
                stall <= draw;
                m_ready <= (draw == 0);
            end else if (stall != 0) begin
                stall <= stall - 1;
                m_ready <= (stall == 1);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        seq_phase = PH_PRE;
        seq_count = '0;
        expo_count = '0;
        peak = '0;
        adj = '{high_thr: HIGH_THR_RESET, low_thr: LOW_THR_RESET, fall_step: FALL_STEP_RESET};
        fails = 0;
        gaps_on = 1'b1;
        frame_done = 1'b0;
        pixels_sent = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (boot_rows[i]) send_pulse(boot_rows[i].sample, 1'b1, boot_rows[i].want);

        // reset thresholds: one below low, then just above high with a tiny exposure
        run_frame(12'd1499, -1, 1'b1);
        run_frame(12'd2501, -1, 1'b1);
        run_frame(12'd0, -1, 1'b1);

        drain();
        write_reg(REG_HIGH_THR, '0);
        write_reg(REG_LOW_THR, '0);
        write_reg(REG_FALL_STEP, '1);
        write_reg(REG_UNUSED, '1);
        run_frame('1, -1, 1'b1);
        run_frame('0, -1, 1'b1);

        drain();
        write_reg(REG_FALL_STEP, '0);
        run_frame(12'd1, -1, 1'b1);
        run_frame('1, -1, 1'b1);

        drain();
        write_reg(REG_HIGH_THR, '1);
        write_reg(REG_LOW_THR, '1);
        run_frame(12'd4094, -1, 1'b1);
        run_frame('1, -1, 1'b1);

        drain();
        write_random_reg(REG_HIGH_THR);
        write_random_reg(REG_LOW_THR);
        write_random_reg(REG_FALL_STEP);
        pixels_sent = 0;
        run_frame(pick_peak(), $urandom_range(0, PIXELS - 1), 1'b1);
        while (pixels_sent < RANDOM_PIXELS) begin
            if ($urandom_range(0, 1) != 0) begin
                drain();
                write_random_reg(CFG_IDX_W'($urandom_range(0, 3)));
            end
            run_frame(pick_peak(), -1, 1'b1);
        end

        drain();
        repeat (8) @(posedge aclk);
        if (fails == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lsrae_pkg.sv
rtl/lsrae_exposure_adj.sv
rtl/linear_sensor_readout_auto_exposure.sv
test/tb.sv
